// File: hdl/ffha_pkg.sv
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int WORD_BYTES_DEF   = 8;
  localparam int HEADER_BYTES_DEF = 32;

  localparam int REQ_W    = 16;
  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int GM_W     = 5;
  localparam int LIM_W    = 17;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 1;
  localparam int X_W      = REQ_W + 1;

  localparam logic [GM_W-1:0]  GM_RESET  = GM_W'(4);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

  localparam logic MODE_FREE = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_PREP,
    OP_PREP2,
    OP_RD_HEAD,
    OP_WALK,
    OP_GROW_HDR,
    OP_GROW_LINK,
    OP_SPLIT_REM,
    OP_SPLIT_IDX,
    OP_FR_MARK,
    OP_FR_RD,
    OP_MN_CHK,
    OP_MN_WRITE,
    OP_MP_CHK,
    OP_MP_WRITE,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ok;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_free;
    logic free_ok;
    logic started;
    logic grow_ok;
    logic mult_gt1;
    logic walk_found;
    logic walk_end;
    logic walk_limit;
    logic rd_free;
    logic nx_null;
    logic pv_null;
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/ffha_in_if.sv
interface ffha_in_if import ffha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [REQ_W-1:0] request_size;
  logic [REQ_W-1:0] free_address;

  modport source (output valid, output mode, output request_size, output free_address,
                  input ready);
  modport sink (input valid, input mode, input request_size, input free_address,
                output ready);
endinterface

// File: hdl/ffha_out_if.sv
interface ffha_out_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] payload_address;
  logic              status;

  modport source (output valid, output payload_address, output status, input ready);
  modport sink (input valid, input payload_address, input status, output ready);
endinterface

// File: hdl/ffha_dp.sv
module ffha_dp import ffha_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int WORD_BYTES   = WORD_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           stat,
  input  logic                 in_mode,
  input  logic [REQ_W-1:0]     in_request_size,
  input  logic [REQ_W-1:0]     in_free_address,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  ffha_out_if.source           out_ch
);

  localparam int DEPTH   = HEAP_BYTES / WORD_BYTES;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LINK_W  = $clog2(DEPTH + 1);
  localparam int HW      = HEADER_BYTES / WORD_BYTES;
  localparam int WB_W    = $clog2(WORD_BYTES + 1);
  localparam int K       = X_W + WB_W;
  localparam int RECIP   = ((2 ** K) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int PROD_W  = X_W + K;
  localparam int SB_W    = X_W + WB_W;
  localparam int SH_W    = SB_W + 1;
  localparam int NW      = X_W + GM_W + 1;
  localparam int NB_W    = NW + WB_W;
  localparam int NBB_W   = NW + 1 + WB_W;
  localparam int REM_W   = LINK_W + X_W;
  localparam int CMP_W   = LINK_W + X_W;
  localparam int PAY_W   = ADDR_W + LINK_W + WB_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(DEPTH);

  logic [SIZE_W-1:0] sz_mem [DEPTH];
  logic              fr_mem [DEPTH];
  logic [LINK_W-1:0] nx_mem [DEPTH];
  logic [LINK_W-1:0] pv_mem [DEPTH];

  logic [SIZE_W-1:0] rd_sz_r;
  logic              rd_fr_r;
  logic [LINK_W-1:0] rd_nx_r;
  logic [LINK_W-1:0] rd_pv_r;

  logic [GM_W-1:0]   gm_r;
  logic [LIM_W-1:0]  lim_r;
  logic [LINK_W-1:0] brk_r, rbrk_r, lwb_r;
  logic              started_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_pay_r;
  logic              out_st_r;

  logic              mode_r, fa_ge_h_r;
  logic [X_W-1:0]    x_r, q_r;
  logic [PROD_W-1:0] prod_r;
  logic              r_zero_r;
  logic [NW-1:0]     need_r;
  logic [SB_W-1:0]   sb_r;
  logic [SH_W-1:0]   sh_r;
  logic              grow_ok_r;
  logic [LINK_W-1:0] cur_r, steps_r;
  logic [LINK_W-1:0] a_idx_r, a_nx_r, a_pv_r;
  logic [SIZE_W-1:0] a_sz_r;

  logic [X_W-1:0]    x_in, q0, q_fix;
  logic [X_W:0]      r0;
  logic              r_zero;
  logic [GM_W-1:0]   gm_eff;
  logic [NB_W-1:0]   need_b;
  logic [NW:0]       nbrk_w;
  logic [NBB_W-1:0]  nbrk_b;
  logic [REM_W-1:0]  rem;
  logic              rem_ok;
  logic              found;
  logic [PAY_W-1:0]  pay;

  logic [IDX_W-1:0]  rd_a, sz_wa, fr_wa, nx_wa, pv_wa;
  logic              sz_we, fr_we, nx_we, pv_we;
  logic [SIZE_W-1:0] sz_wd;
  logic              fr_wd;
  logic [LINK_W-1:0] nx_wd, pv_wd;

  assign x_in   = (in_mode == MODE_FREE)
                  ? X_W'(in_free_address) - X_W'(HEADER_BYTES)
                  : X_W'(in_request_size) + X_W'(WORD_BYTES - 1);
  assign q0     = X_W'(prod_r >> K);
  assign r0     = (X_W + 1)'(x_r) - (X_W + 1)'(q0) * (X_W + 1)'(WORD_BYTES);
  assign q_fix  = (r0 >= (X_W + 1)'(WORD_BYTES)) ? q0 + X_W'(1) : q0;
  assign r_zero = (r0 == '0) || (r0 == (X_W + 1)'(WORD_BYTES));
  assign gm_eff = (gm_r == '0) ? GM_W'(1) : gm_r;
  assign need_b = NB_W'(need_r) * NB_W'(WORD_BYTES);
  assign nbrk_w = (NW + 1)'(brk_r) + (NW + 1)'(need_r);
  assign nbrk_b = NBB_W'(nbrk_w) * NBB_W'(WORD_BYTES);
  assign rem    = REM_W'(a_idx_r) + REM_W'(HW) + REM_W'(q_r);
  assign rem_ok = rem < REM_W'(DEPTH);
  assign found  = rd_fr_r && (SH_W'(rd_sz_r) >= sh_r);
  assign pay    = PAY_W'(a_idx_r) * PAY_W'(WORD_BYTES) + PAY_W'(HEADER_BYTES);

  always_comb begin
    stat.mode_free  = mode_r;
    stat.free_ok    = started_r && fa_ge_h_r && r_zero_r &&
                      (CMP_W'(q_r) <= CMP_W'(rbrk_r)) && (CMP_W'(q_r) < CMP_W'(DEPTH));
    stat.started    = started_r;
    stat.grow_ok    = grow_ok_r;
    stat.mult_gt1   = gm_eff > GM_W'(1);
    stat.walk_found = found;
    stat.walk_end   = rd_nx_r == NULL_LINK;
    stat.walk_limit = ((LINK_W + 1)'(steps_r) + (LINK_W + 1)'(1)) >= (LINK_W + 1)'(DEPTH);
    stat.rd_free    = rd_fr_r;
    stat.nx_null    = rd_nx_r == NULL_LINK;
    stat.pv_null    = rd_pv_r == NULL_LINK;
    stat.out_free   = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    rd_a  = IDX_W'(a_idx_r);
    sz_we = 1'b0;
    fr_we = 1'b0;
    nx_we = 1'b0;
    pv_we = 1'b0;
    sz_wa = IDX_W'(a_idx_r);
    fr_wa = IDX_W'(a_idx_r);
    nx_wa = IDX_W'(a_idx_r);
    pv_wa = IDX_W'(a_idx_r);
    sz_wd = a_sz_r;
    fr_wd = 1'b0;
    nx_wd = NULL_LINK;
    pv_wd = NULL_LINK;
    case (cmd.op)
      OP_RD_HEAD: rd_a = '0;
      OP_WALK:    rd_a = IDX_W'(rd_nx_r);
      OP_MN_CHK:  rd_a = IDX_W'(rd_nx_r);
      OP_MP_CHK:  rd_a = IDX_W'(rd_pv_r);
      OP_GROW_HDR: begin
        sz_we = 1'b1;
        fr_we = 1'b1;
        nx_we = 1'b1;
        pv_we = 1'b1;
        sz_wa = IDX_W'(brk_r);
        fr_wa = IDX_W'(brk_r);
        nx_wa = IDX_W'(brk_r);
        pv_wa = IDX_W'(brk_r);
        sz_wd = SIZE_W'(need_b - NB_W'(HEADER_BYTES));
        pv_wd = started_r ? lwb_r : NULL_LINK;
      end
      OP_GROW_LINK: begin
        nx_we = lwb_r != NULL_LINK;
        nx_wa = IDX_W'(lwb_r);
        nx_wd = a_idx_r;
      end
      OP_SPLIT_REM: begin
        sz_we = rem_ok;
        fr_we = rem_ok;
        nx_we = rem_ok;
        pv_we = rem_ok;
        sz_wa = IDX_W'(rem);
        fr_wa = IDX_W'(rem);
        nx_wa = IDX_W'(rem);
        pv_wa = IDX_W'(rem);
        sz_wd = SIZE_W'(SH_W'(a_sz_r) - sh_r);
        fr_wd = 1'b1;
        nx_wd = a_nx_r;
        pv_wd = a_idx_r;
      end
      OP_SPLIT_IDX: begin
        fr_we = 1'b1;
        sz_we = rem_ok;
        nx_we = rem_ok;
        pv_we = rem_ok && (a_nx_r != NULL_LINK);
        sz_wd = SIZE_W'(sb_r);
        nx_wd = LINK_W'(rem);
        pv_wa = IDX_W'(a_nx_r);
        pv_wd = LINK_W'(rem);
      end
      OP_FR_MARK: begin
        fr_we = 1'b1;
        fr_wa = IDX_W'(q_r);
        fr_wd = 1'b1;
      end
      OP_MN_WRITE: begin
        sz_we = 1'b1;
        nx_we = 1'b1;
        pv_we = rd_nx_r != NULL_LINK;
        sz_wd = a_sz_r + SIZE_W'(HEADER_BYTES) + rd_sz_r;
        nx_wd = rd_nx_r;
        pv_wa = IDX_W'(rd_nx_r);
        pv_wd = a_idx_r;
      end
      OP_MP_WRITE: begin
        sz_we = 1'b1;
        nx_we = 1'b1;
        pv_we = a_nx_r != NULL_LINK;
        sz_wa = IDX_W'(a_pv_r);
        nx_wa = IDX_W'(a_pv_r);
        sz_wd = rd_sz_r + a_sz_r + SIZE_W'(HEADER_BYTES);
        nx_wd = a_nx_r;
        pv_wa = IDX_W'(a_nx_r);
        pv_wd = a_pv_r;
      end
      default: rd_a = IDX_W'(a_idx_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      sz_mem[sz_wa] <= sz_wd;
    end
    if (fr_we) begin
      fr_mem[fr_wa] <= fr_wd;
    end
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    rd_sz_r <= sz_mem[rd_a];
    rd_fr_r <= fr_mem[rd_a];
    rd_nx_r <= nx_mem[rd_a];
    rd_pv_r <= pv_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r        <= GM_RESET;
      lim_r       <= LIM_RESET;
      brk_r       <= '0;
      rbrk_r      <= '0;
      started_r   <= 1'b0;
      lwb_r       <= NULL_LINK;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROWTH: gm_r  <= GM_W'(cfg_wdata);
          CFG_LIMIT:  lim_r <= LIM_W'(cfg_wdata);
          default:    gm_r  <= gm_r;
        endcase
      end
      if (cmd.op == OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_PREP: rbrk_r <= brk_r;
        OP_WALK: begin
          if (!found) begin
            lwb_r <= cur_r;
          end
        end
        OP_GROW_HDR: begin
          brk_r     <= LINK_W'(nbrk_w);
          started_r <= 1'b1;
        end
        default: started_r <= started_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r    <= in_mode;
        fa_ge_h_r <= in_free_address >= REQ_W'(HEADER_BYTES);
        x_r       <= x_in;
        prod_r    <= PROD_W'(x_in) * PROD_W'(RECIP);
      end
      OP_DIV: begin
        q_r      <= q_fix;
        r_zero_r <= r_zero;
      end
      OP_PREP: begin
        need_r <= NW'(gm_eff) * (NW'(q_r) + NW'(HW));
        sb_r   <= SB_W'(q_r) * SB_W'(WORD_BYTES);
        sh_r   <= SH_W'(SB_W'(q_r) * SB_W'(WORD_BYTES)) + SH_W'(HEADER_BYTES);
      end
      OP_PREP2: begin
        grow_ok_r <= (nbrk_b <= NBB_W'(lim_r)) && (nbrk_b <= NBB_W'(HEAP_BYTES)) &&
                     (brk_r < NULL_LINK);
      end
      OP_RD_HEAD: begin
        cur_r   <= '0;
        steps_r <= '0;
      end
      OP_WALK: begin
        if (found) begin
          a_idx_r <= cur_r;
          a_sz_r  <= rd_sz_r;
          a_nx_r  <= rd_nx_r;
        end else begin
          cur_r   <= rd_nx_r;
          steps_r <= steps_r + LINK_W'(1);
        end
      end
      OP_GROW_HDR: begin
        a_idx_r <= brk_r;
        a_sz_r  <= SIZE_W'(need_b - NB_W'(HEADER_BYTES));
        a_nx_r  <= NULL_LINK;
      end
      OP_FR_MARK: a_idx_r <= LINK_W'(q_r);
      OP_MN_CHK, OP_MP_CHK: begin
        a_sz_r <= rd_sz_r;
        a_nx_r <= rd_nx_r;
        a_pv_r <= rd_pv_r;
      end
      OP_FINISH: begin
        out_pay_r <= (cmd.ok && !mode_r) ? ADDR_W'(pay) : '0;
        out_st_r  <= !cmd.ok;
      end
      default: x_r <= x_r;
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.payload_address = out_pay_r;
  assign out_ch.status          = out_st_r;

endmodule

// File: hdl/ffha_ctrl.sv
module ffha_ctrl import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [19:0] {
    S_IDLE       = 20'h00001,
    S_DIV        = 20'h00002,
    S_PREP       = 20'h00004,
    S_PREP2      = 20'h00008,
    S_FREE_CHK   = 20'h00010,
    S_FR_MARK    = 20'h00020,
    S_FR_RD      = 20'h00040,
    S_MN_CHK     = 20'h00080,
    S_MN_EVAL    = 20'h00100,
    S_MP_RD      = 20'h00200,
    S_MP_CHK     = 20'h00400,
    S_MP_EVAL    = 20'h00800,
    S_WALK_START = 20'h01000,
    S_WALK       = 20'h02000,
    S_GROW_FIRST = 20'h04000,
    S_GROW_TAIL  = 20'h08000,
    S_GROW_LINK  = 20'h10000,
    S_SPLIT_REM  = 20'h20000,
    S_SPLIT_IDX  = 20'h40000,
    S_FINISH     = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic   ok_r, ok_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    cmd.op    = OP_NONE;
    cmd.ok    = ok_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        state_nxt = stat.mode_free ? S_FREE_CHK : S_PREP;
      end
      S_FREE_CHK: begin
        ok_nxt    = 1'b0;
        state_nxt = stat.free_ok ? S_FR_MARK : S_FINISH;
      end
      S_FR_MARK: begin
        cmd.op    = OP_FR_MARK;
        state_nxt = S_FR_RD;
      end
      S_FR_RD: begin
        cmd.op    = OP_FR_RD;
        state_nxt = S_MN_CHK;
      end
      S_MN_CHK: begin
        cmd.op    = OP_MN_CHK;
        state_nxt = stat.nx_null ? S_MP_RD : S_MN_EVAL;
      end
      S_MN_EVAL: begin
        cmd.op    = stat.rd_free ? OP_MN_WRITE : OP_NONE;
        state_nxt = S_MP_RD;
      end
      S_MP_RD: begin
        cmd.op    = OP_FR_RD;
        state_nxt = S_MP_CHK;
      end
      S_MP_CHK: begin
        cmd.op    = OP_MP_CHK;
        ok_nxt    = 1'b1;
        state_nxt = stat.pv_null ? S_FINISH : S_MP_EVAL;
      end
      S_MP_EVAL: begin
        cmd.op    = stat.rd_free ? OP_MP_WRITE : OP_NONE;
        ok_nxt    = 1'b1;
        state_nxt = S_FINISH;
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = S_PREP2;
      end
      S_PREP2: begin
        cmd.op = OP_PREP2;
        state_nxt = stat.started ? S_WALK_START : S_GROW_FIRST;
      end
      S_WALK_START: begin
        cmd.op    = OP_RD_HEAD;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.op = OP_WALK;
        if (stat.walk_found) begin
          state_nxt = S_SPLIT_REM;
        end else if (stat.walk_end) begin
          ok_nxt    = 1'b0;
          state_nxt = stat.grow_ok ? S_GROW_TAIL : S_FINISH;
        end else if (stat.walk_limit) begin
          ok_nxt    = 1'b0;
          state_nxt = S_FINISH;
        end
      end
      S_GROW_FIRST: begin
        if (stat.grow_ok) begin
          cmd.op    = OP_GROW_HDR;
          ok_nxt    = 1'b1;
          state_nxt = stat.mult_gt1 ? S_SPLIT_REM : S_FINISH;
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = S_FINISH;
        end
      end
      S_GROW_TAIL: begin
        cmd.op    = OP_GROW_HDR;
        state_nxt = S_GROW_LINK;
      end
      S_GROW_LINK: begin
        cmd.op    = OP_GROW_LINK;
        ok_nxt    = 1'b1;
        state_nxt = stat.mult_gt1 ? S_SPLIT_REM : S_FINISH;
      end
      S_SPLIT_REM: begin
        cmd.op    = OP_SPLIT_REM;
        state_nxt = S_SPLIT_IDX;
      end
      S_SPLIT_IDX: begin
        cmd.op    = OP_SPLIT_IDX;
        ok_nxt    = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
    end
  end

endmodule

// File: hdl/first_fit_heap_allocator.sv
// Channel   Direction  Handshake      Transaction payload
// in_ch     input      valid/ready    mode, request_size, free_address
// out_ch    output     valid/ready    payload_address, status
// cfg_*     input      cfg_we         cfg_index, cfg_wdata (no read-back)
//
// A free is checked, marked free and merged with a free next and then a free previous
// neighbor; a missing neighbor is skipped and a rejected address goes to the result.
// An allocate walks block headers from the head to the first free block that fits;
// if none fits the heap can grow at its end, and the first allocate grows it with no walk.
// The walk is paced by the single read port of the header memory.
// Reset is synchronous; it empties the heap without touching the header memory.
// A new transaction is taken while a result waits; the block stalls only at its end.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int WORD_BYTES   = WORD_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ffha_in_if.sink              in_ch,
  ffha_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .WORD_BYTES   (WORD_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_ch.mode),
    .in_request_size (in_ch.request_size),
    .in_free_address (in_ch.free_address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_ch          (out_ch)
  );

endmodule

// File: hdl/ffha_checker.sv
module ffha_checker import ffha_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_payload,
  input logic              out_status
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  a_fail_has_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_payload == '0)
    else $error("failed transaction carries an address");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(out_status))
    else $error("stalled result changed or dropped");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload_address),
  .out_status  (out_ch.status)
);
